@@ src/ibfpw_pkg.sv @@
`default_nettype none
package ibfpw_pkg;

  localparam int RingBytesDefault = 512;
  localparam int MaxChunksDefault = 64;

  typedef enum logic [1:0] {
    CMD_WRITE    = 2'd0,
    CMD_COMPLETE = 2'd1,
    CMD_START    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_CHUNK_BYTES = 2'd0,
    CFG_CHUNK_COUNT = 2'd1,
    CFG_CHUNKS_IRQ  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BUFSZ,
    ST_RD0,
    ST_RD1,
    ST_HDR,
    ST_EMIT,
    ST_REL_DIV,
    ST_RELEASE,
    ST_CLOSE
  } state_t;

  typedef struct packed {
    logic        packet_valid;
    logic [8:0]  packet_offset;
    logic [9:0]  packet_length;
    logic [5:0]  packet_number;
    logic [6:0]  packet_total;
    logic [6:0]  chunks_released;
    logic [63:0] interrupt_mask;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  quadlet_index;
    logic [31:0] quadlet_data;
    logic [8:0]  completed_offset;
  } item_t;

endpackage
`default_nettype wire

@@ src/ibfpw_if.sv @@
`default_nettype none
interface ibfpw_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/iso_buffer_fill_packet_walker.sv @@
// write beat: stores the quadlet. start beat: drops chunks until the buffer fits the ring, then
// releases every chunk and gives its closing result
// completion beat: drops chunks likewise, reduces the offsets by modulo subtracts, reads each
// header as four byte reads through the one read port, decodes it and emits a result, steps the
// chunk boundaries up to the stop offset, then releases chunks, with a phase subtract first if due
// one item in flight at a time; sync active-low reset clears read offset, phase, registers, control
`default_nettype none
module iso_buffer_fill_packet_walker
  import ibfpw_pkg::*;
#(
  parameter int RING_BYTES = RingBytesDefault,
  parameter int MAX_CHUNKS = MaxChunksDefault
) (
  input  wire   clk,
  input  wire   rst_n,
  ibfpw_if.sink   in_ch,
  ibfpw_if.source out_ch,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [31:0] cfg_data
);

  localparam int Quads = RING_BYTES / 4;
  localparam int QW = $clog2(Quads);

  logic [31:0] ring [Quads];
  logic [31:0] rd_q;

  logic [9:0] cbytes_r;
  logic [6:0] ccount_r;
  logic [5:0] cpi_r;
  logic [8:0] read_offset_r;
  logic [5:0] phase_r;

  state_t state_r, state_nxt;
  item_t  item_r;
  item_t  in_item;
  result_t res_r;
  result_t res_nxt;
  logic    res_ld;
  logic    res_vld_r;

  logic [9:0]  cb_r;
  logic [6:0]  cc_r;
  logic [9:0]  bufsz_r;
  logic [9:0]  prev_r, end_r, accum_r;
  logic [9:0]  off_r;
  logic [6:0]  count_r;
  logic [7:0]  hbytes_r [4];
  logic [1:0]  bi_r;
  logic [16:0] len_r;
  logic [6:0]  rel_r, reli_r;
  logic [63:0] mask_r;
  logic [9:0]  divq_r;
  logic [10:0] divn_r;
  logic        rd_en;
  logic [QW-1:0] rd_addr;

  assign cfg_ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = res_vld_r;
  assign out_ch.payload = res_r;
  assign in_item = item_t'(in_ch.payload);

  wire in_acc = in_ch.valid && in_ch.ready;
  wire out_free = !res_vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbytes_r <= 10'd64;
      ccount_r <= 7'd8;
      cpi_r <= 6'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHUNK_BYTES: cbytes_r <= cfg_data[9:0];
        CFG_CHUNK_COUNT: ccount_r <= cfg_data[6:0];
        CFG_CHUNKS_IRQ:  cpi_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // ring memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && in_item.command == CMD_WRITE &&
        32'(in_item.quadlet_index) < 32'(Quads))
      ring[in_item.quadlet_index[QW-1:0]] <= in_item.quadlet_data;
    if (rd_en) rd_q <= ring[rd_addr];
  end

  // byte address of the current header byte, wrapped
  logic [10:0] baddr;
  always_comb begin
    baddr = 11'(off_r) + 11'(bi_r);
    if (baddr >= 11'(bufsz_r)) baddr = baddr - 11'(bufsz_r);
    rd_addr = baddr[QW+1:2];
    rd_en = (state_r == ST_RD0);
  end

  logic [10:0] avail;
  assign avail = 11'(end_r) - 11'(prev_r) - 11'(accum_r);

  logic emit_ok;
  assign emit_ok = 17'(avail) >= len_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        if (in_item.command == CMD_COMPLETE || in_item.command == CMD_START)
          state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_BUFSZ;
      ST_BUFSZ: begin
        if (item_r.command == CMD_START) begin
          if (divn_r == 11'd2 && prod <= 17'(RING_BYTES)) state_nxt = ST_RELEASE;
        end else if (divn_r == 11'd0) state_nxt = ST_RD0;
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: state_nxt = (bi_r == 2'd3) ? ST_HDR : ST_RD0;
      ST_HDR: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!emit_ok) state_nxt = ST_REL_DIV;
        else if (out_free) begin
          if (count_r == 7'd62 || (avail - 11'(len_r[9:0])) < 11'd4) state_nxt = ST_REL_DIV;
          else state_nxt = ST_RD0;
        end
      end
      ST_REL_DIV: if (divn_r == 11'd0 && divq_r != 10'd0) state_nxt = ST_RELEASE;
      ST_RELEASE: if (reli_r >= rel_r) state_nxt = ST_CLOSE;
      ST_CLOSE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // effective chunk sizing
  logic [10:0] cb_c;
  logic [6:0]  cc_c;
  always_comb begin
    cb_c = (11'(cbytes_r) + 11'd3) & ~11'd3;
    if (cb_c == 11'd0) cb_c = 11'd4;
    if (cb_c > 11'(RING_BYTES & ~3)) cb_c = 11'(RING_BYTES & ~3);
    cc_c = ccount_r;
    if (cc_c == 7'd0) cc_c = 7'd1;
    if (32'(cc_c) > 32'(MAX_CHUNKS)) cc_c = 7'(MAX_CHUNKS);
  end

  // buffer size for the current chunk count
  logic [16:0] prod;
  assign prod = 17'(cb_r) * 17'(cc_r);

  // phase is below the setting whenever a chunk is stepped
  logic        nph_mark;
  logic [6:0]  nph;
  always_comb begin
    nph = 7'(phase_r) + 7'd1;
    if (nph >= 7'(cpi_r)) nph = 7'd0;
    nph_mark = (cpi_r != 6'd0) && (nph == 7'd0);
  end

  always_comb begin
    res_ld = 1'b0;
    res_nxt = '0;
    if (state_r == ST_EMIT && emit_ok && out_free) begin
      res_ld = 1'b1;
      res_nxt.packet_valid = 1'b1;
      res_nxt.packet_offset = off_r[8:0];
      res_nxt.packet_length = len_r[9:0];
      res_nxt.packet_number = count_r[5:0];
    end else if (state_r == ST_CLOSE && out_free) begin
      res_ld = 1'b1;
      res_nxt.packet_total = (item_r.command == CMD_START) ? 7'd0 : count_r;
      res_nxt.chunks_released = rel_r;
      res_nxt.interrupt_mask = mask_r;
      res_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_vld_r <= 1'b0;
      read_offset_r <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_ld) begin
        res_r <= res_nxt;
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (in_acc) item_r <= in_item;
        ST_SETUP: begin
          cb_r <= cb_c[9:0];
          cc_r <= cc_c;
          divn_r <= 11'd2;
        end
        ST_BUFSZ: begin
          if (divn_r == 11'd2) begin
            // reduce count until buffer fits, one chunk per cycle
            if (prod > 17'(RING_BYTES)) begin
              cc_r <= cc_r - 7'd1;
            end else begin
              bufsz_r <= prod[9:0];
              if (item_r.command == CMD_START) begin
                phase_r <= '0;
                rel_r <= cc_r;
                reli_r <= '0;
                mask_r <= '0;
                read_offset_r <= '0;
                count_r <= '0;
              end else begin
                prev_r <= 10'(read_offset_r);
                end_r <= 10'(item_r.completed_offset);
                divn_r <= 11'd3;
              end
            end
          end else if (divn_r == 11'd3) begin
            // modulo by repeated subtracts, walked in place
            if (prev_r >= bufsz_r) prev_r <= prev_r - bufsz_r;
            else if (end_r >= bufsz_r) end_r <= end_r - bufsz_r;
            else begin
              if (end_r < prev_r) end_r <= end_r + bufsz_r;
              accum_r <= '0;
              count_r <= '0;
              off_r <= prev_r;
              bi_r <= '0;
              divn_r <= 11'd0;
            end
          end
        end
        ST_RD1: begin
          hbytes_r[bi_r] <= rd_q[8*baddr[1:0] +: 8];
          bi_r <= bi_r + 2'd1;
        end
        ST_HDR: len_r <= 17'({hbytes_r[3], hbytes_r[2]}) + 17'd8;
        ST_EMIT: begin
          if (emit_ok && out_free) begin
            count_r <= count_r + 7'd1;
            accum_r <= accum_r + len_r[9:0];
            off_r <= (11'(off_r) + 11'(len_r[9:0]) >= 11'(bufsz_r)) ?
                     10'(11'(off_r) + 11'(len_r[9:0]) - 11'(bufsz_r)) : off_r + len_r[9:0];
            bi_r <= '0;
          end
          divq_r <= '0;
          divn_r <= 11'(prev_r);
          rel_r <= '0;
        end
        ST_REL_DIV: begin
          // stop/cb - prev/cb by stepping chunk boundaries
          if (divn_r != 11'd0 || divq_r == 10'd0) begin
            if (divq_r == 10'd0) begin
              divq_r <= 10'd1;
              rel_r <= '0;
              reli_r <= '0;
              mask_r <= '0;
              end_r <= 10'(prev_r) + accum_r;
              prev_r <= prev_r;
              accum_r <= '0;
              divn_r <= 11'd1;
            end else if (11'(accum_r) + 11'(cb_r) <= 11'(end_r)) begin
              accum_r <= accum_r + cb_r;
              if (11'(accum_r) + 11'(cb_r) > 11'(prev_r)) rel_r <= rel_r + 7'd1;
            end else begin
              divn_r <= 11'd0;
              read_offset_r <= (end_r >= bufsz_r) ? 9'(end_r - bufsz_r) : end_r[8:0];
            end
          end
        end
        ST_RELEASE: if (reli_r < rel_r) begin
          // a phase left at or above a smaller setting is brought under it first
          if (cpi_r != 6'd0 && phase_r >= cpi_r) begin
            phase_r <= phase_r - cpi_r;
          end else begin
            if (cpi_r != 6'd0) phase_r <= nph[5:0];
            if (nph_mark) mask_r[reli_r[5:0]] <= 1'b1;
            reli_r <= reli_r + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ dv/walker_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module walker_checker
  import ibfpw_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_ready,
  input  item_t       in_beat,
  input  wire         out_valid,
  input  wire         out_ready,
  input  result_t     out_beat,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire [1:0]   cfg_index,
  input  wire [31:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          walk_offset,
  output int          buf_bytes
);

  localparam int RingQuads = RingBytesDefault / 4;

  logic [31:0] ring_img [RingQuads];
  logic [8:0]  rd_offset;
  logic [5:0]  irq_phase;
  logic [9:0]  chunk_bytes_r;
  logic [6:0]  chunk_count_r;
  logic [5:0]  irq_every;
  result_t     packets_due [$];

  function automatic int chunk_size();
    int cb;
    cb = (int'(chunk_bytes_r) + 3) & ~3;
    if (cb == 0) cb = 4;
    if (cb > (RingBytesDefault & ~3)) cb = RingBytesDefault & ~3;
    return cb;
  endfunction

  function automatic int chunk_total(int cb);
    int cc;
    cc = int'(chunk_count_r);
    if (cc == 0) cc = 1;
    if (cc > MaxChunksDefault) cc = MaxChunksDefault;
    if (cb * cc > RingBytesDefault) cc = RingBytesDefault / cb;
    return cc;
  endfunction

  function automatic logic [7:0] ring_byte(int off);
    logic [31:0] q;
    q = ring_img[off >> 2];
    return q[8 * (off & 3) +: 8];
  endfunction

  // steps the phase by one chunk, true when that chunk raises an interrupt
  function automatic bit chunk_irq();
    int nxt;
    if (irq_every == 0) return 1'b0;
    nxt = (int'(irq_phase) + 1) % int'(irq_every);
    irq_phase = 6'(nxt);
    return nxt == 0;
  endfunction

  function automatic result_t closing(int total, int released, logic [63:0] mask);
    result_t r;
    r = '0;
    r.packet_total = 7'(total);
    r.chunks_released = 7'(released);
    r.interrupt_mask = mask;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic walk_ring(input item_t it);
    int cb, cc, bufsz, prev, stop_at, accum, count, avail, off, len, released;
    logic [31:0] hdr;
    logic [63:0] mask;
    result_t r;
    cb = chunk_size();
    cc = chunk_total(cb);
    bufsz = cb * cc;
    mask = '0;
    case (it.command)
      CMD_WRITE: ring_img[it.quadlet_index] = it.quadlet_data;
      CMD_START: begin
        irq_phase = '0;
        for (int i = 0; i < cc; i++)
          if (chunk_irq()) mask[i] = 1'b1;
        rd_offset = '0;
        packets_due.push_back(closing(0, cc, mask));
      end
      CMD_COMPLETE: begin
        prev = int'(rd_offset) % bufsz;
        stop_at = int'(it.completed_offset) % bufsz;
        if (stop_at < prev) stop_at += bufsz;
        accum = 0;
        count = 0;
        while (count < 63) begin
          avail = stop_at - prev - accum;
          if (avail < 4) break;
          off = (prev + accum) % bufsz;
          for (int b = 0; b < 4; b++) hdr[8 * b +: 8] = ring_byte((off + b) % bufsz);
          len = int'(hdr[31:16]) + 8;
          if (avail < len) break;
          r = '0;
          r.packet_valid = 1'b1;
          r.packet_offset = 9'(off);
          r.packet_length = 10'(len);
          r.packet_number = 6'(count);
          packets_due.push_back(r);
          count++;
          accum += len;
        end
        released = (prev + accum) / cb - prev / cb;
        for (int i = 0; i < released && i < 64; i++)
          if (chunk_irq()) mask[i] = 1'b1;
        rd_offset = 9'((prev + accum) % bufsz);
        packets_due.push_back(closing(count, released, mask));
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      errors = 0;
      rd_offset = '0;
      irq_phase = '0;
      chunk_bytes_r = 10'd64;
      chunk_count_r = 7'd8;
      irq_every = '0;
      packets_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (packets_due.size() == 0) begin
          report("unexpected result beat", 64'(out_beat.packet_offset), 64'd0);
        end else begin
          want = packets_due.pop_front();
          if (out_beat.packet_valid !== want.packet_valid)
            report("packet_valid", 64'(out_beat.packet_valid), 64'(want.packet_valid));
          if (out_beat.packet_offset !== want.packet_offset)
            report("packet_offset", 64'(out_beat.packet_offset), 64'(want.packet_offset));
          if (out_beat.packet_length !== want.packet_length)
            report("packet_length", 64'(out_beat.packet_length), 64'(want.packet_length));
          if (out_beat.packet_number !== want.packet_number)
            report("packet_number", 64'(out_beat.packet_number), 64'(want.packet_number));
          if (out_beat.packet_total !== want.packet_total)
            report("packet_total", 64'(out_beat.packet_total), 64'(want.packet_total));
          if (out_beat.chunks_released !== want.chunks_released)
            report("chunks_released", 64'(out_beat.chunks_released),
                   64'(want.chunks_released));
          if (out_beat.interrupt_mask !== want.interrupt_mask)
            report("interrupt_mask", out_beat.interrupt_mask, want.interrupt_mask);
          if (out_beat.last !== want.last)
            report("last", 64'(out_beat.last), 64'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_CHUNK_BYTES: chunk_bytes_r = cfg_data[9:0];
          CFG_CHUNK_COUNT: chunk_count_r = cfg_data[6:0];
          CFG_CHUNKS_IRQ:  irq_every = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) walk_ring(in_beat);
    end
    pending = packets_due.size();
    buf_bytes = chunk_size() * chunk_total(chunk_size());
    walk_offset = int'(rd_offset) % buf_bytes;
  end

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import ibfpw_pkg::*;

  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int RingQuads = RingBytesDefault / 4;
  localparam int NumPhases = 9;
  localparam int PhaseItems = 4;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  wire cfg_ready;

  ibfpw_if #(.W($bits(item_t))) in_if ();
  ibfpw_if #(.W($bits(result_t))) out_if ();

  int chk_errors, chk_pending, chk_offset, chk_buf;
  logic [31:0] ring_mirror [RingQuads];
  bit steady;
  bit want_hold, held;
  int hold_left;
  int items_sent;

  // chunk bytes, chunk count, chunks per interrupt, one entry per phase
  int phase_cb [NumPhases] = '{64, 4, 512, 16, 8, 6, 0, 1000, 12};
  int phase_cc [NumPhases] = '{8, 1, 1, 32, 64, 100, 0, 3, 20};
  int phase_ci [NumPhases] = '{0, 0, 0, 5, 63, 70, 3, 2, 7};

  always #5 clk = ~clk;

  iso_buffer_fill_packet_walker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  walker_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .in_beat(item_t'(in_if.payload)),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .out_beat(result_t'(out_if.payload)),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(chk_errors),
    .pending(chk_pending),
    .walk_offset(chk_offset),
    .buf_bytes(chk_buf)
  );

  // result side: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
      held <= 1'b0;
    end else if (want_hold && !held) begin
      held <= 1'b1;
      hold_left <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= steady || ($urandom_range(99) >= 7);
    end
  end

  task automatic send_item(input item_t it);
    bit took;
    if (!steady && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= it;
    do begin
      @(negedge clk);
      took = in_if.ready;
      @(posedge clk);
    end while (!took);
    if (it.command == CMD_WRITE) ring_mirror[it.quadlet_index] = it.quadlet_data;
    items_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input int idx, input logic [31:0] data,
                          input int offset);
    item_t it;
    it.command = cmd;
    it.quadlet_index = 7'(idx);
    it.quadlet_data = data;
    it.completed_offset = 9'(offset);
    send_item(it);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
  endtask

  // lets the block drain, then covers the latency of a trailing write or start
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (chk_pending != 0);
    repeat (100) @(posedge clk);
  endtask

  // writes the header of a packet of len bytes at byte position pos
  task automatic put_header(input int pos, input int len, input int bufsz);
    logic [31:0] hdr;
    int p, q0, q1;
    hdr = {16'(len - 8), 16'($urandom)};
    for (int b = 0; b < 4; b++) begin
      p = (pos + b) % bufsz;
      ring_mirror[p >> 2][8 * (p & 3) +: 8] = hdr[8 * b +: 8];
    end
    q0 = pos >> 2;
    q1 = ((pos + 3) % bufsz) >> 2;
    send_cmd(CMD_WRITE, q0, ring_mirror[q0], $urandom_range(511));
    if (q1 != q0) send_cmd(CMD_WRITE, q1, ring_mirror[q1], $urandom_range(511));
  endtask

  task automatic packet_run(input bit burst);
    int o, bufsz, total, n, len, endo;
    wait_idle();
    @(negedge clk);
    o = chk_offset;
    bufsz = chk_buf;
    @(posedge clk);
    n = burst ? 64 : $urandom_range(1, 5);
    total = 0;
    for (int k = 0; k < n; k++) begin
      if (burst) len = 8;
      else if ($urandom_range(9) == 0) len = $urandom_range(8, 300);
      else len = 8 + $urandom_range(40);
      if (total + len > bufsz - 4) break;
      put_header((o + total) % bufsz, len, bufsz);
      total += len;
    end
    endo = o + total;
    case ($urandom_range(3))
      0: endo += $urandom_range(3);
      1: if (total > 0) endo -= $urandom_range(1, 3);
      default: ;
    endcase
    endo = (endo + bufsz) % bufsz;
    if (endo + bufsz < 512 && $urandom_range(1)) endo += bufsz;
    send_cmd(CMD_COMPLETE, $urandom_range(127), $urandom, endo);
  endtask

  task automatic noise_item();
    int pick;
    logic [1:0] cmd;
    pick = $urandom_range(99);
    if (pick < 50) cmd = CMD_WRITE;
    else if (pick < 88) cmd = CMD_COMPLETE;
    else if (pick < 95) cmd = CMD_START;
    else cmd = CmdUnknown;
    send_cmd(cmd, $urandom_range(127), $urandom, $urandom_range(511));
  endtask

  initial begin
    #30ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int goal, w;
    in_if.valid <= 1'b0;
    in_if.payload <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CHUNK_BYTES;
    cfg_data <= '0;
    rst_n <= 1'b0;
    steady = 1'b0;
    want_hold = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // every quadlet gets written before any walk can read it
    for (int q = 0; q < RingQuads; q++) send_cmd(CMD_WRITE, q, $urandom, 0);

    // directed: extremes, unknown command, unaligned chain, oversized header
    send_cmd(CMD_START, 0, '0, 0);
    send_cmd(CMD_COMPLETE, 127, 32'hffff_ffff, 0);
    send_cmd(CMD_WRITE, 127, 32'hffff_ffff, 511);
    send_cmd(CMD_WRITE, 0, 32'h0000_abcd, 0);
    send_cmd(CMD_WRITE, 2, 32'h0001_0000, 0);
    send_cmd(CMD_WRITE, 4, 32'h0000_0000, 0);
    send_cmd(CMD_WRITE, 5, 32'hffff_ff00, 0);
    send_cmd(CMD_WRITE, 6, 32'hffff_ffff, 0);
    send_cmd(CMD_WRITE, 7, 32'hffff_ffff, 0);
    send_cmd(CmdUnknown, 127, 32'hffff_ffff, 511);
    send_cmd(CMD_COMPLETE, 0, '0, 511);
    send_cmd(CMD_COMPLETE, 0, '0, 0);
    send_cmd(CMD_START, 127, 32'hffff_ffff, 511);
    send_cmd(CMD_WRITE, 0, 32'h0000_0000, 0);
    send_cmd(CMD_COMPLETE, 0, '0, 8);

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      if (ph > 0) begin
        cfg_write(CFG_CHUNK_BYTES, phase_cb[ph]);
        cfg_write(CFG_CHUNK_COUNT, phase_cc[ph]);
        cfg_write(CFG_CHUNKS_IRQ, phase_ci[ph]);
      end
      steady = (ph == 2);
      send_cmd(CMD_START, $urandom_range(127), $urandom, $urandom_range(511));
      goal = items_sent + PhaseItems;
      if (ph == 2) packet_run(1'b1);
      if (ph == 3) begin
        // sender keeps offering while results are held back
        want_hold = 1'b1;
        for (int k = 0; k < 24; k++) noise_item();
      end
      while (items_sent < goal) begin
        if ($urandom_range(99) < 80) packet_run(1'b0);
        else noise_item();
      end
    end
    steady = 1'b0;

    in_if.valid <= 1'b0;
    w = 0;
    while (w < 50000 && chk_pending != 0) begin
      @(negedge clk);
      w++;
    end
    repeat (100) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/ibfpw_pkg.sv
src/ibfpw_if.sv
src/iso_buffer_fill_packet_walker.sv
dv/walker_checker.sv
dv/testbench.sv
